>>> design/mwo_pkg.sv
// Shared types and constants for the morphing wavetable oscillator.
package mwo_pkg;

	// Table and number formats
	localparam int TABLE_LENGTH = 1024;
	localparam int IDX_W        = $clog2(TABLE_LENGTH);
	localparam int FRAC_W       = 16;
	localparam int PHASE_W      = IDX_W + FRAC_W;
	localparam int INC_W        = 26;
	localparam int SAMPLE_W     = 16;
	localparam int ENV_W        = 16;
	localparam int MORPH_W      = 17;
	localparam int UNIT_SHIFT   = 15;

	// Derived arithmetic widths
	localparam int STEP_P_W = INC_W + ENV_W;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int LERP_P_W = DIFF_W + FRAC_W + 1;
	localparam int MIX_P_W  = MORPH_W + DIFF_W;

	localparam logic signed [MORPH_W-1:0] MORPH_ONE = MORPH_W'(1 << UNIT_SHIFT);

	// Command queue, depth a power of two so the pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_PHASE_INC = 1'b0;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_WRITE  = 1'b1
	} op_t;

	typedef enum logic {
		TAB_FIRST  = 1'b0,
		TAB_SECOND = 1'b1
	} tab_sel_t;

	typedef struct packed {
		op_t                        op;
		logic [ENV_W-1:0]           envelope;
		logic signed [MORPH_W-1:0]  morph;
		tab_sel_t                   tab;
		logic [IDX_W-1:0]           index;
		logic signed [SAMPLE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_LERP,
		ST_MIX,
		ST_OUT
	} back_state_t;

endpackage

>>> design/mwo_front.sv
// Front end: takes input transactions, classifies them and queues them for the back end.
module mwo_front import mwo_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [ENV_W-1:0]           envelope,
	input  logic signed [MORPH_W-1:0]  morph,
	input  logic                       table_select,
	input  logic [IDX_W-1:0]           write_index,
	input  logic signed [SAMPLE_W-1:0] write_value,
	output q_head_t                    head,
	input  logic                       pop
);

	cmd_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	cmd_t              cmd_in;

	// Classify the incoming transaction
	always_comb begin
		cmd_in.op       = opcode ? OP_WRITE : OP_SAMPLE;
		cmd_in.envelope = envelope;
		cmd_in.morph    = morph;
		cmd_in.tab      = table_select ? TAB_SECOND : TAB_FIRST;
		cmd_in.index    = write_index;
		cmd_in.value    = write_value;
	end

	assign in_stall   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("pop from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a push");
`endif

endmodule

>>> design/mwo_back.sv
// Back end: table memories, phase accumulator, interpolation, morph and result register.
module mwo_back import mwo_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [INC_W-1:0]           phase_inc,
	input  q_head_t                    head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [PHASE_W-1:0]         phase
);

	back_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] tab_a [TABLE_LENGTH];
	logic signed [SAMPLE_W-1:0] tab_b [TABLE_LENGTH];

	logic                        start;
	logic                        wr_a, wr_b;
	logic                        out_load;
	logic [STEP_P_W-1:0]         step_full;
	logic [PHASE_W-1:0]          step_q;
	logic signed [MORPH_W-1:0]   morph_q;
	logic [PHASE_W-1:0]          phase_q;
	logic [PHASE_W-1:0]          phase_next;
	logic [IDX_W-1:0]            rd_idx, rd_idx_nx;
	logic signed [SAMPLE_W-1:0]  a1_q, b1_q, a2_q, b2_q;
	logic signed [DIFF_W-1:0]    frac_s;
	logic signed [LERP_P_W-1:0]  lp1_q, lp2_q;
	logic signed [LERP_P_W-1:0]  v1_w, v2_w;
	logic signed [SAMPLE_W-1:0]  v1, v2;
	logic signed [SAMPLE_W-1:0]  v1_q;
	logic signed [MIX_P_W-1:0]   mix_q;
	logic signed [MIX_P_W-1:0]   s_w;
	logic [MIX_P_W-SAMPLE_W:0]   s_top;
	logic signed [SAMPLE_W-1:0]  s_sat;
	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  sample_q;
	logic [PHASE_W-1:0]          phase_out_q;

	// Dispatch from the queue head
	assign pop   = (state_q == ST_IDLE) && head.valid;
	assign start = pop && (head.cmd.op == OP_SAMPLE);
	assign wr_a  = pop && (head.cmd.op == OP_WRITE) && (head.cmd.tab == TAB_FIRST);
	assign wr_b  = pop && (head.cmd.op == OP_WRITE) && (head.cmd.tab == TAB_SECOND);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Step product and phase wrap (modulus is a power of two)
	assign step_full  = STEP_P_W'(phase_inc) * STEP_P_W'(head.cmd.envelope);
	assign phase_next = phase_q + step_q;
	assign rd_idx     = phase_next[PHASE_W-1 -: IDX_W];
	assign rd_idx_nx  = rd_idx + 1'b1;

	// Table memories: one write port, two read ports each
	always_ff @(posedge clk) begin
		if (wr_a) begin
			tab_a[head.cmd.index] <= head.cmd.value;
		end
		if (state_q == ST_ACC) begin
			a1_q <= tab_a[rd_idx];
			b1_q <= tab_a[rd_idx_nx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			tab_b[head.cmd.index] <= head.cmd.value;
		end
		if (state_q == ST_ACC) begin
			a2_q <= tab_b[rd_idx];
			b2_q <= tab_b[rd_idx_nx];
		end
	end

	// Interpolation and crossfade datapath
	assign frac_s = $signed({1'b0, phase_q[FRAC_W-1:0]});
	assign v1_w   = LERP_P_W'(a1_q) + (lp1_q >>> FRAC_W);
	assign v2_w   = LERP_P_W'(a2_q) + (lp2_q >>> FRAC_W);
	assign v1     = v1_w[SAMPLE_W-1:0];
	assign v2     = v2_w[SAMPLE_W-1:0];
	assign s_w    = MIX_P_W'(v1_q) + (mix_q >>> UNIT_SHIFT);
	assign s_top  = s_w[MIX_P_W-1:SAMPLE_W-1];

	// Saturate to the sample width
	always_comb begin
		if ((&s_top) || !(|s_top)) begin
			s_sat = s_w[SAMPLE_W-1:0];
		end else if (s_w[MIX_P_W-1]) begin
			s_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			s_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			step_q  <= step_full[UNIT_SHIFT +: PHASE_W];
			morph_q <= (head.cmd.morph > MORPH_ONE) ? MORPH_ONE : head.cmd.morph;
		end
		if (state_q == ST_LERP) begin
			lp1_q <= frac_s * (DIFF_W'(b1_q) - DIFF_W'(a1_q));
			lp2_q <= frac_s * (DIFF_W'(b2_q) - DIFF_W'(a2_q));
		end
		if (state_q == ST_MIX) begin
			v1_q  <= v1;
			mix_q <= morph_q * (DIFF_W'(v2) - DIFF_W'(v1));
		end
		if (out_load) begin
			sample_q    <= s_sat;
			phase_out_q <= phase_q;
		end
	end

	// Sequencer state and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) begin
				phase_q <= phase_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC:  state_d = ST_LERP;
			ST_LERP: state_d = ST_MIX;
			ST_MIX:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign phase     = phase_out_q;

`ifndef NO_ASSERTIONS
	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##3 (state_q == ST_OUT))
		else $error("sample sequence length wrong");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACC) |=> $stable(phase_q))
		else $error("phase changed outside accumulate step");

	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_load) |=> (state_q == ST_OUT && out_valid_q))
		else $error("result dropped while output busy");

	a_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && phase == $past(phase_q)))
		else $error("result phase mismatch");
`endif

endmodule

>>> design/morphing_wavetable_oscillator.sv
// Top level of the morphing wavetable oscillator: configuration register and block wiring.
// A sample transaction passes through the back end in order: step multiply, phase accumulate
// with table read, two interpolation multiplies, morph multiply, saturate into the result
// register. This single sequencer pops no new transaction until that result is loaded.
// A table write is applied as it is popped. A four-entry queue sits between input and
// back end, so input is taken while a result waits to be collected. Table entries read
// before they are written hold unknown values. phase_increment is at byte address 0.
module morphing_wavetable_oscillator import mwo_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [ENV_W-1:0]           envelope,
	input  logic signed [MORPH_W-1:0]  morph,
	input  logic                       table_select,
	input  logic [IDX_W-1:0]           write_index,
	input  logic signed [SAMPLE_W-1:0] write_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [PHASE_W-1:0]         phase,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [CFG_ADDR_W-1:0]      paddr,
	input  logic [CFG_DATA_W-1:0]      pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	logic [INC_W-1:0] phase_inc_q;
	logic             reg_sel;
	q_head_t          head;
	logic             pop;

	// Configuration register, selected by word address
	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= '0;
		end else if (psel && penable && pwrite && pready && (reg_sel == REG_PHASE_INC)) begin
			phase_inc_q <= pwdata[INC_W-1:0];
		end
	end

	always_comb begin
		if (reg_sel == REG_PHASE_INC) begin
			prdata = CFG_DATA_W'(phase_inc_q);
		end else begin
			prdata = '0;
		end
	end

	mwo_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.envelope     (envelope),
		.morph        (morph),
		.table_select (table_select),
		.write_index  (write_index),
		.write_value  (write_value),
		.head         (head),
		.pop          (pop)
	);

	mwo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.phase_inc (phase_inc_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample),
		.phase     (phase)
	);

endmodule

>>> tb/mwo_sample_checker.sv
`timescale 1ns / 1ps
// Transaction checker for the morphing wavetable oscillator: predicts and compares samples.
module mwo_sample_checker import mwo_pkg::*; (
	input  logic                       clk,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  op_t                        opcode,
	input  logic [ENV_W-1:0]           envelope,
	input  logic signed [MORPH_W-1:0]  morph,
	input  tab_sel_t                   table_select,
	input  logic [IDX_W-1:0]           write_index,
	input  logic signed [SAMPLE_W-1:0] write_value,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [PHASE_W-1:0]         phase,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [CFG_ADDR_W-1:0]      paddr,
	input  logic [CFG_DATA_W-1:0]      pwdata,
	input  logic [CFG_DATA_W-1:0]      prdata,
	input  logic                       pready,
	output int                         mismatches,
	output int                         pending,
	output int                         samples_checked,
	output int                         writes_seen
);

	localparam logic [CFG_ADDR_W-1:0] INC_ADDR = CFG_ADDR_W'(REG_PHASE_INC) << 2;
	localparam longint SAT_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [PHASE_W-1:0]         phase;
	} tone_t;

	// Shadow copy of the block's register, accumulator and wavetables
	logic [INC_W-1:0]           inc_reg = '0;
	logic [PHASE_W-1:0]         acc     = '0;
	logic signed [SAMPLE_W-1:0] wave_mem [2][TABLE_LENGTH];
	tone_t                      tone_q [$];

	// Linear interpolation between entry i and the next one, last entry wrapping to the first
	function automatic longint lerp(tab_sel_t t, logic [IDX_W-1:0] i, logic [FRAC_W-1:0] f);
		logic [IDX_W-1:0] j;
		longint a, b;
		j = i + 1'b1;
		a = wave_mem[t][i];
		b = wave_mem[t][j];
		return a + ((longint'(f) * (b - a)) >>> FRAC_W);
	endfunction

	// Advance the accumulator and work out the sample this transaction should give
	function automatic tone_t next_tone(logic [ENV_W-1:0] env, logic signed [MORPH_W-1:0] m_in);
		logic [STEP_P_W-1:0] prod;
		longint v1, v2, m, s;
		tone_t t;
		prod = inc_reg * env;
		acc  = acc + PHASE_W'(prod >> UNIT_SHIFT);
		v1 = lerp(TAB_FIRST, acc[PHASE_W-1:FRAC_W], acc[FRAC_W-1:0]);
		v2 = lerp(TAB_SECOND, acc[PHASE_W-1:FRAC_W], acc[FRAC_W-1:0]);
		m = m_in;
		if (m > MORPH_ONE) begin
			m = MORPH_ONE;
		end
		s = v1 + ((m * (v2 - v1)) >>> UNIT_SHIFT);
		if (s > SAT_HI) begin
			s = SAT_HI;
		end
		if (s < SAT_LO) begin
			s = SAT_LO;
		end
		t.sample = SAMPLE_W'(s);
		t.phase  = acc;
		return t;
	endfunction

	always @(posedge clk) begin
		tone_t want;
		// register port: writes update the shadow, reads are compared
		if (psel && penable && pready && paddr == INC_ADDR) begin
			if (pwrite) begin
				inc_reg = pwdata[INC_W-1:0];
			end else if (prdata !== CFG_DATA_W'(inc_reg)) begin
				$error("phase_increment readback: expected %0h, got %0h", inc_reg, prdata);
				mismatches++;
			end
		end
		// input transaction
		if (in_valid && !in_stall) begin
			if (opcode == OP_WRITE) begin
				wave_mem[table_select][write_index] = write_value;
				writes_seen++;
			end else begin
				tone_q.push_back(next_tone(envelope, morph));
			end
		end
		// output transaction against the oldest expectation
		if (out_valid && !out_stall) begin
			if (tone_q.size() == 0) begin
				$error("sample transaction with none expected: sample %0d, phase %0h",
					sample, phase);
				mismatches++;
			end else begin
				want = tone_q.pop_front();
				samples_checked++;
				if (sample !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample, sample);
					mismatches++;
				end
				if (phase !== want.phase) begin
					$error("phase: expected %0h, got %0h", want.phase, phase);
					mismatches++;
				end
			end
		end
		pending = tone_q.size();
	end

endmodule

>>> tb/tb_morphing_wavetable_oscillator.sv
`timescale 1ns / 1ps
// Testbench top for the morphing wavetable oscillator: stimulus, handshake pacing and verdict.
module tb_morphing_wavetable_oscillator;
	import mwo_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 400;
	localparam int RANDOM_PHASES = 8;
	localparam logic [CFG_ADDR_W-1:0] INC_ADDR = CFG_ADDR_W'(REG_PHASE_INC) << 2;
	localparam logic signed [SAMPLE_W-1:0] ENTRY_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] ENTRY_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [MORPH_W-1:0]  MORPH_MAX = {1'b0, {(MORPH_W-1){1'b1}}};
	localparam logic signed [MORPH_W-1:0]  MORPH_MIN = {1'b1, {(MORPH_W-1){1'b0}}};
	localparam logic [ENV_W-1:0]           ENV_UNIT  = ENV_W'(1 << UNIT_SHIFT);

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	op_t                        opcode       = OP_SAMPLE;
	logic [ENV_W-1:0]           envelope     = '0;
	logic signed [MORPH_W-1:0]  morph        = '0;
	tab_sel_t                   table_select = TAB_FIRST;
	logic [IDX_W-1:0]           write_index  = '0;
	logic signed [SAMPLE_W-1:0] write_value  = '0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic [PHASE_W-1:0]         phase;
	logic                       psel         = 1'b0;
	logic                       penable      = 1'b0;
	logic                       pwrite       = 1'b0;
	logic [CFG_ADDR_W-1:0]      paddr        = '0;
	logic [CFG_DATA_W-1:0]      pwdata       = '0;
	logic [CFG_DATA_W-1:0]      prdata;
	logic                       pready;

	int mismatches, pending, samples_checked, writes_seen;
	int items_sent    = 0;
	int settings_done = 0;

	// pacing controls shared between the sender and the receiver
	bit idle_on      = 1'b1;
	bit hold_pending = 1'b0;

	// stimulus-side tracking so that no unwritten entry is ever read
	logic [INC_W-1:0]   inc_now   = '0;
	logic [PHASE_W-1:0] phase_now = '0;
	bit                 loaded [2][TABLE_LENGTH];

	morphing_wavetable_oscillator DUT (.*);

	mwo_sample_checker sample_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("morphing_wavetable_oscillator test failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= idle_on && ($urandom_range(99) < 15);
		end
	end

	// offer one input transaction and wait until it is taken
	task automatic offer(op_t op, logic [ENV_W-1:0] env, logic signed [MORPH_W-1:0] m,
			tab_sel_t t, logic [IDX_W-1:0] i, logic signed [SAMPLE_W-1:0] v);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		opcode       <= op;
		envelope     <= env;
		morph        <= m;
		table_select <= t;
		write_index  <= i;
		write_value  <= v;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (op == OP_WRITE) begin
			loaded[t][i] = 1'b1;
		end
	endtask

	task automatic load_entry(tab_sel_t t, logic [IDX_W-1:0] i, logic signed [SAMPLE_W-1:0] v);
		offer(OP_WRITE, ENV_W'($urandom), MORPH_W'($urandom), t, i, v);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(5))
			0: return ENTRY_MAX;
			1: return ENTRY_MIN;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [ENV_W-1:0] pick_envelope();
		case ($urandom_range(9))
			0: return '0;
			1: return ENV_UNIT;
			2: return '1;
			3, 4, 5: return ENV_W'($urandom);
			default: return ENV_W'($urandom_range(1 << UNIT_SHIFT));
		endcase
	endfunction

	function automatic logic signed [MORPH_W-1:0] pick_morph();
		case ($urandom_range(9))
			0: return MORPH_ONE;
			1: return MORPH_MAX;
			2: return MORPH_MIN;
			3, 4: return MORPH_W'($urandom);
			5: return -MORPH_W'($urandom_range(1 << UNIT_SHIFT));
			default: return MORPH_W'($urandom_range(1 << UNIT_SHIFT));
		endcase
	endfunction

	function automatic logic [INC_W-1:0] pick_increment(int kind);
		case (kind % 5)
			0: return INC_W'($urandom_range(1 << FRAC_W));
			1: return INC_W'($urandom);
			2: return INC_W'($urandom_range(1 << 20));
			3: return '1;
			default: return '0;
		endcase
	endfunction

	// sample transaction; the four entries it will read are loaded first if still blank
	task automatic play(logic [ENV_W-1:0] env, logic signed [MORPH_W-1:0] m);
		logic [STEP_P_W-1:0] prod;
		logic [PHASE_W-1:0]  next;
		logic [IDX_W-1:0]    i, j;
		prod = inc_now * env;
		next = phase_now + PHASE_W'(prod >> UNIT_SHIFT);
		i    = next[PHASE_W-1:FRAC_W];
		for (int t = 0; t < 2; t++) begin
			for (int k = 0; k < 2; k++) begin
				j = i + IDX_W'(k);
				if (!loaded[t][j]) begin
					load_entry(tab_sel_t'(t), j, pick_value());
				end
			end
		end
		offer(OP_SAMPLE, env, m, tab_sel_t'($urandom_range(1)), IDX_W'($urandom),
			SAMPLE_W'($urandom));
		phase_now = next;
	endtask

	// one register access: setup cycle, then access cycle until pready
	task automatic cfg_access(bit wr, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= INC_ADDR;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_increment(logic [INC_W-1:0] v);
		cfg_access(1'b1, CFG_DATA_W'(v));
		cfg_access(1'b0, '0);
		inc_now = v;
		settings_done++;
	endtask

	// drain: every expected sample out, then time for any trailing table writes
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int quota;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset value readback
		cfg_access(1'b0, '0);

		// zero increment: extremes at entries 0 and 1, morph clamp and extrapolation
		load_entry(TAB_FIRST, 0, ENTRY_MAX);
		load_entry(TAB_SECOND, 0, ENTRY_MIN);
		load_entry(TAB_FIRST, 1, ENTRY_MIN);
		load_entry(TAB_SECOND, 1, ENTRY_MAX);
		play('1, '0);
		play('0, MORPH_ONE);
		play(ENV_UNIT, MORPH_MAX);
		play(ENV_W'($urandom), MORPH_MIN);
		play(ENV_W'($urandom), '1);

		// land on the last entry so the read wraps to the first
		settle();
		set_increment(INC_W'(((TABLE_LENGTH - 1) << FRAC_W) | (1 << (FRAC_W - 1))));
		play(ENV_UNIT, MORPH_W'(1 << (UNIT_SHIFT - 1)));
		play('0, pick_morph());

		// largest increment: steps just short of a whole table length, wrapping the phase
		settle();
		set_increment('1);
		play('1, pick_morph());
		play(ENV_UNIT, pick_morph());

		// random phases, one increment setting each
		for (int s = 0; s < RANDOM_PHASES; s++) begin
			settle();
			set_increment(pick_increment(s));
			@(posedge clk);
			idle_on = (s != 5);
			if (s == 2) begin
				hold_pending = 1'b1;
			end
			quota = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
			while (items_sent < quota) begin
				if ($urandom_range(3) == 0) begin
					load_entry(tab_sel_t'($urandom_range(1)), IDX_W'($urandom), pick_value());
				end else begin
					play(pick_envelope(), pick_morph());
				end
			end
		end

		settle();
		$display("Run covered %0d samples over %0d increment settings and %0d table writes",
			samples_checked, settings_done, writes_seen);
		$display("including a %0d-cycle output hold-off and a stretch with no idling",
			HOLD_CYCLES);
		if (mismatches == 0 && pending == 0) begin
			$display("morphing_wavetable_oscillator test passed");
		end else begin
			$display("morphing_wavetable_oscillator test failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/mwo_pkg.sv
design/mwo_front.sv
design/mwo_back.sv
design/morphing_wavetable_oscillator.sv
tb/mwo_sample_checker.sv
tb/tb_morphing_wavetable_oscillator.sv
